### sv/paids_pkg.sv
// ============================================================================
// paids_pkg
// Shared types and codes for the positional array insert/delete/search core.
// ============================================================================
package paids_pkg;

    // Default number of entries held
    localparam int unsigned DEPTH_DEFAULT = 64;

    // Command codes
    localparam logic [1:0] CMD_REPORT = 2'd0;
    localparam logic [1:0] CMD_FIND   = 2'd1;
    localparam logic [1:0] CMD_INSERT = 2'd2;
    localparam logic [1:0] CMD_DELETE = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Request transaction
    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] value;
        logic [6:0]         position;
    } req_t;

    // Response transaction
    typedef struct packed {
        logic               found;
        logic [5:0]         found_index;
        logic signed [31:0] max_value;
        logic signed [31:0] min_value;
        logic [6:0]         entry_count;
        logic               is_empty;
        logic [1:0]         status;
    } rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // latch request, check range, set index
        logic sh_rd;      // read shift source entry
        logic sh_wr;      // write shift destination entry, step index
        logic put;        // write inserted value, count up
        logic del;        // count down
        logic scan_init;  // clear scan results, index to zero
        logic scan_rd;    // read next entry for the scan
        logic out_load;   // load response register
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic ins_go;     // valid insert pending
        logic del_go;     // valid delete pending
        logic sh_more;    // more entries to move
        logic scan_more;  // more entries to scan
    } dp_stat_t;

endpackage

### sv/paids_dp.sv
// ============================================================================
// paids_dp
// Datapath: entry memory, count, shift/scan index, search and min/max
// accumulation, and the response register.
// ============================================================================
module paids_dp #(
    parameter int unsigned DEPTH = paids_pkg::DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  paids_pkg::req_t   req,
    input  paids_pkg::dp_cmd_t cmd,
    output paids_pkg::dp_stat_t stat,
    output paids_pkg::rsp_t   rsp
);
    import paids_pkg::*;

    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW   = $clog2(DEPTH + 1);
    localparam int unsigned PW   = 7;
    localparam int unsigned CMPW = (CW > PW) ? CW : PW;

    // Entry memory
    logic [31:0]        mem [DEPTH];
    logic [31:0]        rd_data_reg;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [31:0]        wr_data;

    // Transaction registers
    logic [1:0]         cmd_reg;
    logic signed [31:0] val_reg;
    logic [PW-1:0]      pos_reg;
    logic [1:0]         status_reg, status_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      idx_m1, idx_p1;

    // Scan pipeline and results
    logic               scan_vld_reg;
    logic [AW-1:0]      acc_idx_reg;
    logic               found_reg;
    logic [AW-1:0]      found_idx_reg;
    logic signed [31:0] max_reg, min_reg;
    logic signed [31:0] rd_value;
    rsp_t               rsp_reg;

    assign idx_m1   = idx_reg - CW'(1);
    assign idx_p1   = idx_reg + CW'(1);
    assign rd_value = $signed(rd_data_reg);

    // Memory port selection
    always_comb
    begin
        rd_en = cmd.sh_rd | cmd.scan_rd;
        if (cmd.scan_rd)
        begin
            rd_addr = idx_reg[AW-1:0];
        end
        else if (cmd_reg == CMD_INSERT)
        begin
            rd_addr = idx_m1[AW-1:0];
        end
        else
        begin
            rd_addr = idx_p1[AW-1:0];
        end
        wr_en   = cmd.sh_wr | cmd.put;
        wr_addr = cmd.put ? AW'(pos_reg) : idx_reg[AW-1:0];
        wr_data = cmd.put ? val_reg : rd_data_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Range and capacity check of a new request
    always_comb
    begin
        status_next = ST_OK;
        if (req.command == CMD_INSERT)
        begin
            if (CMPW'(req.position) > CMPW'(count_reg))
            begin
                status_next = ST_RANGE;
            end
            else if (count_reg >= CW'(DEPTH))
            begin
                status_next = ST_FULL;
            end
        end
        else if (req.command == CMD_DELETE)
        begin
            if (CMPW'(req.position) >= CMPW'(count_reg))
            begin
                status_next = ST_RANGE;
            end
        end
    end

    // Index and count updates
    always_comb
    begin
        idx_next   = idx_reg;
        count_next = count_reg;
        if (cmd.load)
        begin
            idx_next = (req.command == CMD_INSERT) ? count_reg : CW'(req.position);
        end
        else if (cmd.sh_wr)
        begin
            idx_next = (cmd_reg == CMD_INSERT) ? idx_m1 : idx_p1;
        end
        else if (cmd.scan_rd)
        begin
            idx_next = idx_p1;
        end
        if (cmd.scan_init)
        begin
            idx_next = '0;
        end
        if (cmd.put)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.del)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            scan_vld_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            scan_vld_reg <= cmd.scan_rd;
        end
    end

    // Request latch, index, scan accumulation
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.load)
        begin
            cmd_reg    <= req.command;
            val_reg    <= req.value;
            pos_reg    <= req.position;
            status_reg <= status_next;
        end
        if (cmd.scan_rd)
        begin
            acc_idx_reg <= idx_reg[AW-1:0];
        end
        if (cmd.scan_init)
        begin
            found_reg     <= 1'b0;
            found_idx_reg <= '0;
            max_reg       <= '0;
            min_reg       <= '0;
        end
        else if (scan_vld_reg)
        begin
            if (acc_idx_reg == '0)
            begin
                max_reg <= rd_value;
                min_reg <= rd_value;
            end
            else
            begin
                if (rd_value > max_reg)
                begin
                    max_reg <= rd_value;
                end
                if (rd_value < min_reg)
                begin
                    min_reg <= rd_value;
                end
            end
            if (cmd_reg == CMD_FIND && !found_reg && rd_value == val_reg)
            begin
                found_reg     <= 1'b1;
                found_idx_reg <= acc_idx_reg;
            end
        end
        if (cmd.out_load)
        begin
            rsp_reg.found       <= found_reg;
            rsp_reg.found_index <= 6'(found_idx_reg);
            rsp_reg.max_value   <= max_reg;
            rsp_reg.min_value   <= min_reg;
            rsp_reg.entry_count <= 7'(count_reg);
            rsp_reg.is_empty    <= (count_reg == '0);
            rsp_reg.status      <= status_reg;
        end
    end

    // Status to controller
    always_comb
    begin
        stat.ins_go    = (cmd_reg == CMD_INSERT) && (status_reg == ST_OK);
        stat.del_go    = (cmd_reg == CMD_DELETE) && (status_reg == ST_OK);
        stat.sh_more   = (cmd_reg == CMD_INSERT) ? (CMPW'(idx_reg) > CMPW'(pos_reg))
                                                 : (idx_p1 < count_reg);
        stat.scan_more = idx_reg < count_reg;
    end

    assign rsp = rsp_reg;

endmodule

### sv/paids_ctrl.sv
// ============================================================================
// paids_ctrl
// Controller: sequences request latch, entry shifting, the search/min/max
// scan and the response handoff.
// ============================================================================
module paids_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    input  paids_pkg::dp_stat_t stat,
    output paids_pkg::dp_cmd_t  cmd
);
    import paids_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_SHWR  = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       rsp_valid_reg, rsp_valid_next;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.ins_go || stat.del_go)
                begin
                    state_next = S_SHIFT;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SHIFT:
            begin
                if (stat.sh_more)
                begin
                    cmd.sh_rd  = 1'b1;
                    state_next = S_SHWR;
                end
                else
                begin
                    cmd.put       = stat.ins_go;
                    cmd.del       = stat.del_go;
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SHWR:
            begin
                cmd.sh_wr  = 1'b1;
                state_next = S_SHIFT;
            end
            S_SCAN:
            begin
                if (stat.scan_more)
                begin
                    cmd.scan_rd = 1'b1;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Response valid
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

### sv/positional_array_insert_delete_search_core.sv
// ============================================================================
// positional_array_insert_delete_search_core
// Ordered store of signed 32-bit entries with insert, delete and search.
// ============================================================================
// Usage:
//   Request channel (req_valid/req_stall/req) carries one command per
//   transaction: report, find value, insert value at position, or delete at
//   position. Response channel (rsp_valid/rsp_stall/rsp) returns one
//   transaction per request with search result, max/min, count, empty flag
//   and status.
// Timing:
//   One request at a time. Entries sit in a single-port-read memory, so an
//   insert or delete moves each entry with a read state (S_SHIFT) and then
//   a write state (S_SHWR), and the max/min/find scan reads one entry per
//   cycle. req_stall drops at the edge that raises rsp_valid.
// Reset:
//   rst_n clears the count (store empty) and the controller; the memory
//   itself is not cleared.
// Stall:
//   A finished response waits in the output register while rsp_stall is
//   high; a new request may be taken meanwhile but its own response holds
//   until the register frees.
// ============================================================================
module positional_array_insert_delete_search_core #(
    parameter int unsigned DEPTH = paids_pkg::DEPTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  paids_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output paids_pkg::rsp_t rsp
);
    import paids_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    paids_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    paids_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (rsp)
    );

`ifndef NO_ASSERTIONS
    // One request in flight: accepted request blocks the next cycle
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted while another is in flight");

    // Empty store reports zero max and min
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.is_empty |-> rsp.max_value == '0 && rsp.min_value == '0)
        else $error("empty store with nonzero max/min");

    // Max never below min when entries are held
    a_max_ge_min: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.is_empty |-> rsp.max_value >= rsp.min_value)
        else $error("max below min");

    // A hit only comes from a successful find
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.found |-> rsp.status == ST_OK)
        else $error("found set with error status");
`endif

endmodule
